@@ sv/lcti_pkg.sv @@
// Shared constants and types for the Lagrange cubic table interpolator.
`timescale 1ns / 1ps

package lcti_pkg;

    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int CFG_W         = 11;
    localparam int CFG_LEN_RESET = 1024;
    localparam int POS_W         = 32;
    localparam int FRAC_W        = 16;
    localparam int WIDX_W        = 10;
    localparam int NTAPS         = 4;

    // Index arithmetic width: holds any table depth and a tap offset of -1.
    localparam int CMP_W = 18;

    // Weight datapath: numerator factors, split products, Q2.16 weight.
    localparam int XW    = 33;
    localparam int YW    = 20;
    localparam int XH_W  = XW - FRAC_W;
    localparam int PP_W  = 37;
    localparam int U_W   = 21;
    localparam int WGT_W = 18;

    // floor(u / 6) as (u * RECIP6) >> RECIP_SHIFT, exact for u below 2^U_W.
    localparam int              RECIP_W     = 22;
    localparam logic [21:0]     RECIP6      = 22'd2796203;
    localparam int              RECIP_SHIFT = 24;
    localparam int              Q_W         = U_W + RECIP_W;
    // Bias of 6 * 2^18 keeps the dividend positive; it falls out of the weight bits.
    localparam int              DIV_BIAS    = 6 * (1 << 18) + 3;

    localparam int PIPE_DEPTH = 7;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_opcode;

    typedef struct packed {
        logic valid;
        logic oor;
        logic last;
    } t_meta;

endpackage

@@ sv/lagrange_cubic_table_interpolator.sv @@
// Four-point cubic Lagrange interpolator over a four-way banked sample table.
// Results: a query accepted at a clock edge passes through the registered stages in order and
// is on the result ports for one cycle; writes and queries advance in step.
// Throughput: one item per cycle, writes and queries mixed freely; busy only rises in reset.
// A write takes no result slot; a query takes exactly one strobed cycle.
// Reset (synchronous, active low) empties the pipeline and sets table_length to min(1024,
// TABLE_DEPTH); the table itself is not cleared, and the receiver cannot stall the result.
`timescale 1ns / 1ps

module lagrange_cubic_table_interpolator
    import lcti_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_opcode,
    input  logic [POS_W-1:0]              i_position,
    input  logic [WIDX_W-1:0]             i_write_index,
    input  logic signed [SAMPLE_BITS-1:0] i_write_sample,
    input  logic                          i_last_in,
    input  logic                          i_cfg_we,
    input  logic [CFG_W-1:0]              i_cfg_wdata,
    output logic                          o_strobe,
    output logic signed [SAMPLE_BITS-1:0] o_interpolated_value,
    output logic                          o_saturated,
    output logic                          o_out_of_range,
    output logic                          o_last_out
);

    // ------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------
    localparam int IDX_W      = $clog2(TABLE_DEPTH);
    localparam int BANK_DEPTH = (TABLE_DEPTH + 3) / 4;
    localparam int BANK_AW    = (IDX_W > 2) ? IDX_W - 2 : 1;
    localparam int LEN_RST    = (CFG_LEN_RESET < TABLE_DEPTH) ? CFG_LEN_RESET : TABLE_DEPTH;
    localparam int PROD_W     = SAMPLE_BITS + WGT_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int VAL_W      = SUM_W - FRAC_W;

    localparam logic [CMP_W-1:0]        DEPTH_C  = CMP_W'(TABLE_DEPTH);
    localparam logic [IDX_W-1:0]        LAST_RST = IDX_W'(LEN_RST - 1);
    localparam logic signed [CMP_W-1:0] S_C      = CMP_W'(1 << FRAC_W);
    localparam logic signed [SUM_W-1:0] HALF_C   = SUM_W'(1 << (FRAC_W - 1));
    localparam logic signed [VAL_W-1:0] SMAX     =
        VAL_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [VAL_W-1:0] SMIN     = -SMAX - VAL_W'(1);
    localparam logic signed [U_W:0]     BIAS_C   = (U_W + 1)'(DIV_BIAS);

    // ------------------------------------------------------------------
    // Handshake and configuration
    // ------------------------------------------------------------------
    logic             r_busy;
    logic             accept;
    logic [IDX_W-1:0] r_last_idx;   // effective table length minus one
    logic [IDX_W-1:0] n_last_idx;
    logic [CMP_W-1:0] cfg_len;

    assign busy   = r_busy;
    assign accept = start && !r_busy;

    // Hold busy through reset and clear it once reset is released.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    // Clamp the programmed length to 1..TABLE_DEPTH and keep it as a last index.
    always_comb begin
        cfg_len = CMP_W'(i_cfg_wdata);
        priority if (cfg_len == '0) begin
            n_last_idx = '0;
        end else if (cfg_len > DEPTH_C) begin
            n_last_idx = IDX_W'(DEPTH_C - CMP_W'(1));
        end else begin
            n_last_idx = IDX_W'(cfg_len - CMP_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_idx <= LAST_RST;
        end else if (i_cfg_we) begin
            r_last_idx <= n_last_idx;
        end
    end

    // ------------------------------------------------------------------
    // Table write, done at the accepting edge so any later query sees it.
    // Entry i lives in bank i mod 4 at row i / 4.
    // ------------------------------------------------------------------
    logic [CMP_W-1:0]   widx_ext;
    logic [IDX_W-1:0]   widx;
    logic [IDX_W+1:0]   widx_pad;
    logic [BANK_AW-1:0] wr_addr;
    logic               wr_en;

    assign widx_ext = CMP_W'(i_write_index);
    assign widx     = widx_ext[IDX_W-1:0];
    assign widx_pad = {2'b00, widx};
    assign wr_addr  = widx_pad[BANK_AW+1:2];
    // Drop writes that fall beyond the table.
    assign wr_en    = accept && (t_opcode'(i_opcode) == OP_WRITE) && (widx_ext < DEPTH_C);

    // ------------------------------------------------------------------
    // Stage 1: split the position, clamp the four neighbour indices.
    // ------------------------------------------------------------------
    logic [FRAC_W-1:0]        ipart;
    logic signed [CMP_W-1:0]  tap_pos [NTAPS];
    logic [IDX_W-1:0]         n1_idx  [NTAPS];
    logic [IDX_W-1:0]         r1_idx  [NTAPS];
    logic [FRAC_W-1:0]        r1_frac;
    t_meta                    n_meta;
    t_meta                    r_meta [PIPE_DEPTH];

    assign ipart = i_position[POS_W-1:FRAC_W];

    always_comb begin
        for (int k = 0; k < NTAPS; k++) begin
            tap_pos[k] = signed'(CMP_W'(ipart) + CMP_W'(k) - CMP_W'(1));
            priority if (tap_pos[k] < 0) begin
                n1_idx[k] = '0;
            end else if (tap_pos[k] > signed'(CMP_W'(r_last_idx))) begin
                n1_idx[k] = r_last_idx;
            end else begin
                n1_idx[k] = tap_pos[k][IDX_W-1:0];
            end
        end
        n_meta.valid = accept && (t_opcode'(i_opcode) == OP_QUERY);
        // The position is flagged but still goes through the clamp.
        n_meta.oor   = CMP_W'(ipart) > CMP_W'(r_last_idx);
        n_meta.last  = i_last_in;
    end

    always_ff @(posedge i_clk) begin
        r1_frac <= i_position[FRAC_W-1:0];
        for (int k = 0; k < NTAPS; k++) begin
            r1_idx[k] <= n1_idx[k];
        end
    end

    // Valid bits and flags travel alongside the data, one slot per stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < PIPE_DEPTH; s++) begin
                r_meta[s] <= '0;
            end
        end else begin
            r_meta[0] <= n_meta;
            for (int s = 1; s < PIPE_DEPTH; s++) begin
                r_meta[s] <= r_meta[s-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: banked table read and the first weight products.
    // The clamped taps are monotonic and span at most four entries, so
    // each bank is read at one row only.
    // ------------------------------------------------------------------
    logic [IDX_W+1:0]           tap_pad [NTAPS];
    logic [BANK_AW-1:0]         rd_addr [NTAPS];
    logic signed [SAMPLE_BITS-1:0] r2_rd [NTAPS];
    logic [1:0]                 r2_sel  [NTAPS];

    always_comb begin
        for (int k = 0; k < NTAPS; k++) begin
            tap_pad[k] = {2'b00, r1_idx[k]};
        end
        for (int b = 0; b < NTAPS; b++) begin
            rd_addr[b] = '0;
            for (int k = NTAPS - 1; k >= 0; k--) begin
                if (r1_idx[k][1:0] == 2'(b)) begin
                    rd_addr[b] = tap_pad[k][BANK_AW+1:2];
                end
            end
        end
    end

    for (genvar b = 0; b < NTAPS; b++) begin : g_bank
        logic signed [SAMPLE_BITS-1:0] r_mem [BANK_DEPTH];

        always_ff @(posedge i_clk) begin
            if (wr_en && (widx[1:0] == 2'(b))) begin
                r_mem[wr_addr] <= i_write_sample;
            end
            r2_rd[b] <= r_mem[rd_addr[b]];
        end
    end

    // Weight numerators over 6*S^3 as X * Y:
    //   w0 = F(F-S) * (2S-F)       w1 = (F+S)(F-S) * 3(F-2S)
    //   w2 = F(F-2S) * -3(F+S)     w3 = F(F-S) * (F+S)
    logic signed [CMP_W-1:0]   f_s, f_m1, f_p1, f_m2;
    logic signed [2*CMP_W-1:0] p_a, p_c, p_d;
    logic signed [YW-1:0]      y_m2, y_p1;
    logic signed [XW-1:0]      n2_x [NTAPS];
    logic signed [YW-1:0]      n2_y [NTAPS];
    logic signed [XW-1:0]      r2_x [NTAPS];
    logic signed [YW-1:0]      r2_y [NTAPS];

    always_comb begin
        f_s  = signed'({2'b00, r1_frac});
        f_m1 = f_s - S_C;
        f_p1 = f_s + S_C;
        f_m2 = f_m1 - S_C;
        p_a  = f_s * f_m1;
        p_c  = f_p1 * f_m1;
        p_d  = f_s * f_m2;
        y_m2 = YW'(f_m2);
        y_p1 = YW'(f_p1);
        n2_x[0] = XW'(p_a);
        n2_x[1] = XW'(p_c);
        n2_x[2] = XW'(p_d);
        n2_x[3] = XW'(p_a);
        n2_y[0] = -y_m2;
        n2_y[1] = (y_m2 <<< 1) + y_m2;
        n2_y[2] = -((y_p1 <<< 1) + y_p1);
        n2_y[3] = y_p1;
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NTAPS; k++) begin
            r2_x[k]   <= n2_x[k];
            r2_y[k]   <= n2_y[k];
            r2_sel[k] <= r1_idx[k][1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: numerator as two partial products; route banks to taps.
    // ------------------------------------------------------------------
    logic signed [PP_W-1:0]        r3_ph  [NTAPS];
    logic signed [PP_W-1:0]        r3_pl  [NTAPS];
    logic signed [SAMPLE_BITS-1:0] r3_smp [NTAPS];
    logic signed [XH_W-1:0]        x_hi   [NTAPS];
    logic signed [FRAC_W:0]        x_lo   [NTAPS];

    always_comb begin
        for (int k = 0; k < NTAPS; k++) begin
            x_hi[k] = r2_x[k][XW-1:FRAC_W];
            x_lo[k] = signed'({1'b0, r2_x[k][FRAC_W-1:0]});
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NTAPS; k++) begin
            r3_ph[k]  <= PP_W'(x_hi[k] * r2_y[k]);
            r3_pl[k]  <= PP_W'(x_lo[k] * r2_y[k]);
            r3_smp[k] <= r2_rd[r2_sel[k]];
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: floor(num / S^2) + 3, biased positive for the divide by 6.
    // ------------------------------------------------------------------
    logic signed [PP_W:0]          num_hi [NTAPS];
    logic signed [U_W:0]           u_full [NTAPS];
    logic [U_W-1:0]                r4_u   [NTAPS];
    logic signed [SAMPLE_BITS-1:0] r4_smp [NTAPS];

    always_comb begin
        for (int k = 0; k < NTAPS; k++) begin
            num_hi[k] = (PP_W + 1)'(r3_ph[k]) + (PP_W + 1)'(r3_pl[k] >>> FRAC_W);
            u_full[k] = signed'(num_hi[k][PP_W:FRAC_W]) + BIAS_C;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NTAPS; k++) begin
            r4_u[k]   <= u_full[k][U_W-1:0];
            r4_smp[k] <= r3_smp[k];
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: divide by 6 through the reciprocal.
    // ------------------------------------------------------------------
    logic [Q_W-1:0]                r5_q   [NTAPS];
    logic signed [SAMPLE_BITS-1:0] r5_smp [NTAPS];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NTAPS; k++) begin
            r5_q[k]   <= Q_W'(r4_u[k]) * Q_W'(RECIP6);
            r5_smp[k] <= r4_smp[k];
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: weight the samples. The bias lands above the weight bits.
    // ------------------------------------------------------------------
    logic signed [WGT_W-1:0]  wgt   [NTAPS];
    logic signed [WGT_W+1:0]  wgt_sum;
    logic signed [PROD_W-1:0] r6_prod [NTAPS];

    always_comb begin
        wgt_sum = '0;
        for (int k = 0; k < NTAPS; k++) begin
            wgt[k]  = signed'(r5_q[k][RECIP_SHIFT +: WGT_W]);
            wgt_sum = wgt_sum + (WGT_W + 2)'(wgt[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NTAPS; k++) begin
            r6_prod[k] <= PROD_W'(r5_smp[k] * wgt[k]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: sum, round half up, saturate, register the result.
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0]       acc;
    logic signed [SUM_W-1:0]       acc_rnd;
    logic signed [VAL_W-1:0]       val;
    logic signed [SAMPLE_BITS-1:0] n_value;
    logic                          n_sat;
    logic signed [SAMPLE_BITS-1:0] r7_value;
    logic                          r7_sat;

    always_comb begin
        acc = '0;
        for (int k = 0; k < NTAPS; k++) begin
            acc = acc + SUM_W'(r6_prod[k]);
        end
        acc_rnd = acc + HALF_C;
        val     = signed'(acc_rnd[SUM_W-1:FRAC_W]);
        priority if (val > SMAX) begin
            n_value = SAMPLE_BITS'(SMAX);
            n_sat   = 1'b1;
        end else if (val < SMIN) begin
            n_value = SAMPLE_BITS'(SMIN);
            n_sat   = 1'b1;
        end else begin
            n_value = SAMPLE_BITS'(val);
            n_sat   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r7_value <= n_value;
        r7_sat   <= n_sat;
    end

    assign o_strobe             = r_meta[PIPE_DEPTH-1].valid;
    assign o_out_of_range       = r_meta[PIPE_DEPTH-1].oor;
    assign o_last_out           = r_meta[PIPE_DEPTH-1].last;
    assign o_interpolated_value = r7_value;
    assign o_saturated          = r7_sat;

`ifndef SYNTHESIS
    a_query_gives_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_opcode == OP_QUERY)) |-> ##PIPE_DEPTH o_strobe)
        else $error("query item lost in the pipeline");

    a_write_gives_none : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_opcode == OP_WRITE)) |-> ##PIPE_DEPTH !o_strobe)
        else $error("table write produced a result");

    a_weights_partition : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_meta[4].valid |-> (wgt_sum >= 65534 && wgt_sum <= 65538))
        else $error("Lagrange weights do not sum to one");

    a_ready_after_reset : assert property (@(posedge i_clk)
        $rose(i_rst_n) |=> !busy)
        else $error("busy stuck after reset");
`endif

endmodule
